>>> design/sac_pkg.sv
`default_nettype none

package sac_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int TIME_FRAC_BITS_DEF = 16;
    localparam int AXIS_COUNT_DEF     = 3;

    localparam int AXIS_WIDTH   = 2;
    localparam int EPS_WIDTH    = 17;
    localparam int NORMAL_WIDTH = 3;

    localparam logic [EPS_WIDTH-1:0]    EPS_RESET        = EPS_WIDTH'(66);
    localparam logic [AXIS_WIDTH-1:0]   AXIS_START       = '0;
    localparam logic [NORMAL_WIDTH-1:0] NORMAL_NONE      = '0;
    localparam logic [NORMAL_WIDTH-1:0] NORMAL_MINUS_OFS = NORMAL_WIDTH'(1);
    localparam logic [NORMAL_WIDTH-1:0] NORMAL_PLUS_OFS  = NORMAL_WIDTH'(2);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PREP  = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_SIGN  = 7'b0010000,
        ST_MERGE = 7'b0100000,
        ST_FINAL = 7'b1000000
    } sac_state_t;

    typedef struct packed {
        logic start;
        logic done;
    } sac_div_ctl_t;

endpackage

`default_nettype wire

>>> design/sac_if.sv
`default_nettype none

interface sac_in_if #(
    parameter int COORD_WIDTH = sac_pkg::COORD_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic        [sac_pkg::AXIS_WIDTH-1:0] axis_index;
    logic signed [COORD_WIDTH-1:0]       moving_min;
    logic signed [COORD_WIDTH-1:0]       moving_max;
    logic signed [COORD_WIDTH-1:0]       target_min;
    logic signed [COORD_WIDTH-1:0]       target_max;
    logic signed [COORD_WIDTH-1:0]       velocity;

    modport source (
        output valid, axis_index, moving_min, moving_max, target_min, target_max, velocity,
        input  ready
    );
    modport sink (
        input  valid, axis_index, moving_min, moving_max, target_min, target_max, velocity,
        output ready
    );
endinterface

interface sac_out_if #(
    parameter int TIME_FRAC_BITS = sac_pkg::TIME_FRAC_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [TIME_FRAC_BITS:0]           hit_time;
    logic [sac_pkg::NORMAL_WIDTH-1:0]  normal_code;

    modport source (
        output valid, hit, hit_time, normal_code,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_time, normal_code,
        output ready
    );
endinterface

interface sac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sac_pkg::EPS_WIDTH-1:0]  data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

>>> design/swept_aabb_collision.sv
// Each axis walks the states idle, prep, check, divide, sign, merge and final; a static or
// already rejected axis goes from check straight to final. A new transaction is accepted
// only in idle. The last axis's result is presented in the cycle after its final step.
// Throughput is set by the restoring divider, one quotient bit per cycle for both slab edges.
// Reset clears all control, sets eps_velocity to 66 and the test to entry 0, exit 1.0.
`default_nettype none

module swept_aabb_collision #(
    parameter int COORD_WIDTH    = sac_pkg::COORD_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = sac_pkg::TIME_FRAC_BITS_DEF,
    parameter int AXIS_COUNT     = sac_pkg::AXIS_COUNT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sac_cfg_if.sink   cfg,
    sac_in_if.sink    items,
    sac_out_if.source results
);

    localparam int MW   = COORD_WIDTH + 1;
    localparam int TW   = TIME_FRAC_BITS + 3;
    localparam int QW   = TIME_FRAC_BITS + 1;
    localparam int AW   = sac_pkg::AXIS_WIDTH;
    localparam int NW   = sac_pkg::NORMAL_WIDTH;
    localparam int EW   = sac_pkg::EPS_WIDTH;
    localparam int CMPW = (COORD_WIDTH > EW) ? COORD_WIDTH : EW;
    localparam logic signed [TW-1:0] TIME_ONE  = {3'b001, {TIME_FRAC_BITS{1'b0}}};
    localparam logic signed [TW-1:0] TIME_SAT  = {3'b010, {TIME_FRAC_BITS{1'b0}}};
    localparam logic [AW:0]          AXIS_LIM  = (AW + 1)'(AXIS_COUNT);
    localparam logic [AW-1:0]        AXIS_LAST = AW'(AXIS_COUNT - 1);

    sac_pkg::sac_state_t state_reg, state_next;

    logic [EW-1:0]          eps_reg, eps_next;
    logic signed [TW-1:0]   entry_reg, entry_next;
    logic signed [TW-1:0]   exit_reg, exit_next;
    logic [NW-1:0]          normal_reg, normal_next;
    logic                   rejected_reg, rejected_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   hit_reg, hit_next;
    logic [QW-1:0]          hit_time_reg, hit_time_next;
    logic [NW-1:0]          code_reg, code_next;

    logic [AW-1:0]          axis_reg;
    logic signed [MW-1:0]   near_reg, far_reg;
    logic signed [COORD_WIDTH-1:0] vel_reg;
    logic [MW-1:0]          nmag_reg, fmag_reg;
    logic [COORD_WIDTH-1:0] vmag_reg;
    logic                   nneg_reg, fneg_reg, vneg_reg;
    logic                   near_pos_reg, far_neg_reg;
    logic                   sat_a_reg, sat_b_reg;
    logic signed [TW-1:0]   t1_reg, t2_reg;

    logic                   accept;
    logic                   axis_ok;
    logic                   is_static;
    logic                   sat_a, sat_b;
    logic [MW-1:0]          twice_d;
    logic signed [TW-1:0]   mag_a, mag_b;
    logic                   flip;
    logic signed [TW-1:0]   t_lo, t_hi;
    logic                   rej_now;
    logic                   out_free;

    sac_pkg::sac_div_ctl_t  div_ctl;
    logic                   div_start;
    logic [QW-1:0]          quot_a, quot_b;

    sac_div #(
        .COORD_WIDTH    (COORD_WIDTH),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_a  (nmag_reg),
        .num_b  (fmag_reg),
        .den    (vmag_reg),
        .ctl    (div_ctl),
        .quot_a (quot_a),
        .quot_b (quot_b)
    );

    assign items.ready = (state_reg == sac_pkg::ST_IDLE);
    assign accept      = items.valid && items.ready;
    assign axis_ok     = {1'b0, items.axis_index} < AXIS_LIM;
    assign cfg.ready   = 1'b1;

    assign is_static = (vmag_reg == '0) || (CMPW'(vmag_reg) < CMPW'(eps_reg));
    assign twice_d   = {vmag_reg, 1'b0};
    assign sat_a     = nmag_reg >= twice_d;
    assign sat_b     = fmag_reg >= twice_d;

    assign mag_a = sat_a_reg ? TIME_SAT : TW'(quot_a);
    assign mag_b = sat_b_reg ? TIME_SAT : TW'(quot_b);

    assign flip  = t1_reg > t2_reg;
    assign t_lo  = flip ? t2_reg : t1_reg;
    assign t_hi  = flip ? t1_reg : t2_reg;

    assign rej_now  = rejected_reg || (entry_reg > exit_reg);
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next     = state_reg;
        eps_next       = eps_reg;
        entry_next     = entry_reg;
        exit_next      = exit_reg;
        normal_next    = normal_reg;
        rejected_next  = rejected_reg;
        out_valid_next = out_valid_reg && !results.ready;
        hit_next       = hit_reg;
        hit_time_next  = hit_time_reg;
        code_next      = code_reg;
        div_start      = 1'b0;

        if (cfg.valid)
        begin
            eps_next = cfg.data;
        end

        unique case (state_reg)
            sac_pkg::ST_IDLE:
            begin
                if (accept && axis_ok)
                begin
                    state_next = sac_pkg::ST_PREP;
                    if (items.axis_index == sac_pkg::AXIS_START)
                    begin
                        entry_next    = '0;
                        exit_next     = TIME_ONE;
                        normal_next   = sac_pkg::NORMAL_NONE;
                        rejected_next = 1'b0;
                    end
                end
            end
            sac_pkg::ST_PREP:
            begin
                state_next = sac_pkg::ST_CHECK;
            end
            sac_pkg::ST_CHECK:
            begin
                if (rejected_reg)
                begin
                    state_next = sac_pkg::ST_FINAL;
                end
                else if (is_static)
                begin
                    if (near_pos_reg || far_neg_reg)
                    begin
                        rejected_next = 1'b1;
                    end
                    state_next = sac_pkg::ST_FINAL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = sac_pkg::ST_DIV;
                end
            end
            sac_pkg::ST_DIV:
            begin
                if (div_ctl.done)
                begin
                    state_next = sac_pkg::ST_SIGN;
                end
            end
            sac_pkg::ST_SIGN:
            begin
                state_next = sac_pkg::ST_MERGE;
            end
            sac_pkg::ST_MERGE:
            begin
                if (t_lo > entry_reg)
                begin
                    entry_next  = t_lo;
                    normal_next = {axis_reg, 1'b0}
                                + (flip ? sac_pkg::NORMAL_PLUS_OFS : sac_pkg::NORMAL_MINUS_OFS);
                end
                if (t_hi < exit_reg)
                begin
                    exit_next = t_hi;
                end
                state_next = sac_pkg::ST_FINAL;
            end
            sac_pkg::ST_FINAL:
            begin
                rejected_next = rej_now;
                if (axis_reg != AXIS_LAST)
                begin
                    state_next = sac_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = !rej_now && (entry_reg < TIME_ONE);
                    hit_time_next  = rej_now ? '0 : entry_reg[QW-1:0];
                    code_next      = rej_now ? sac_pkg::NORMAL_NONE : normal_reg;
                    state_next     = sac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sac_pkg::ST_IDLE;
            eps_reg       <= sac_pkg::EPS_RESET;
            entry_reg     <= '0;
            exit_reg      <= TIME_ONE;
            normal_reg    <= sac_pkg::NORMAL_NONE;
            rejected_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eps_reg       <= eps_next;
            entry_reg     <= entry_next;
            exit_reg      <= exit_next;
            normal_reg    <= normal_next;
            rejected_reg  <= rejected_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        hit_time_reg <= hit_time_next;
        code_reg     <= code_next;
        if (accept)
        begin
            axis_reg <= items.axis_index;
            near_reg <= {items.target_min[COORD_WIDTH-1], items.target_min}
                      - {items.moving_max[COORD_WIDTH-1], items.moving_max};
            far_reg  <= {items.target_max[COORD_WIDTH-1], items.target_max}
                      - {items.moving_min[COORD_WIDTH-1], items.moving_min};
            vel_reg  <= items.velocity;
        end
        if (state_reg == sac_pkg::ST_PREP)
        begin
            nmag_reg     <= near_reg[MW-1] ? (-near_reg) : near_reg;
            fmag_reg     <= far_reg[MW-1] ? (-far_reg) : far_reg;
            vmag_reg     <= vel_reg[COORD_WIDTH-1] ? (-vel_reg) : vel_reg;
            nneg_reg     <= near_reg[MW-1];
            fneg_reg     <= far_reg[MW-1];
            vneg_reg     <= vel_reg[COORD_WIDTH-1];
            near_pos_reg <= !near_reg[MW-1] && (near_reg != '0);
            far_neg_reg  <= far_reg[MW-1];
        end
        if (state_reg == sac_pkg::ST_CHECK)
        begin
            sat_a_reg <= sat_a;
            sat_b_reg <= sat_b;
        end
        if (state_reg == sac_pkg::ST_SIGN)
        begin
            t1_reg <= (nneg_reg != vneg_reg) ? (-mag_a) : mag_a;
            t2_reg <= (fneg_reg != vneg_reg) ? (-mag_b) : mag_b;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.hit         = hit_reg;
    assign results.hit_time    = hit_time_reg;
    assign results.normal_code = code_reg;

endmodule

`default_nettype wire

>>> design/sac_div.sv
`default_nettype none

module sac_div #(
    parameter int COORD_WIDTH    = sac_pkg::COORD_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = sac_pkg::TIME_FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [COORD_WIDTH:0]        num_a,
    input  wire logic [COORD_WIDTH:0]        num_b,
    input  wire logic [COORD_WIDTH-1:0]      den,
    output sac_pkg::sac_div_ctl_t            ctl,
    output logic      [TIME_FRAC_BITS:0]     quot_a,
    output logic      [TIME_FRAC_BITS:0]     quot_b
);

    localparam int MW   = COORD_WIDTH + 1;
    localparam int QW   = TIME_FRAC_BITS + 1;
    localparam int CNTW = $clog2(QW);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(TIME_FRAC_BITS);

    logic            run_reg, run_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0]   rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [COORD_WIDTH-1:0] den_reg, den_next;
    logic [QW-1:0]   q_a_reg, q_a_next, q_b_reg, q_b_next;

    logic [MW-1:0]   den_ext;
    logic            ge_a, ge_b;
    logic [MW-1:0]   part_a, part_b;
    logic            last;

    assign den_ext = {1'b0, den_reg};
    assign ge_a    = rem_a_reg >= den_ext;
    assign ge_b    = rem_b_reg >= den_ext;
    assign part_a  = ge_a ? (rem_a_reg - den_ext) : rem_a_reg;
    assign part_b  = ge_b ? (rem_b_reg - den_ext) : rem_b_reg;
    assign last    = run_reg && (cnt_reg == CNT_LAST);

    always_comb
    begin
        run_next   = run_reg;
        cnt_next   = cnt_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        den_next   = den_reg;
        q_a_next   = q_a_reg;
        q_b_next   = q_b_reg;
        if (start)
        begin
            run_next   = 1'b1;
            cnt_next   = '0;
            rem_a_next = num_a;
            rem_b_next = num_b;
            den_next   = den;
            q_a_next   = '0;
            q_b_next   = '0;
        end
        else if (run_reg)
        begin
            rem_a_next = {part_a[MW-2:0], 1'b0};
            rem_b_next = {part_b[MW-2:0], 1'b0};
            q_a_next   = {q_a_reg[QW-2:0], ge_a};
            q_b_next   = {q_b_reg[QW-2:0], ge_b};
            cnt_next   = cnt_reg + CNTW'(1);
            if (last)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        den_reg   <= den_next;
        q_a_reg   <= q_a_next;
        q_b_reg   <= q_b_next;
    end

    assign ctl.start = start;
    assign ctl.done  = last;
    assign quot_a    = q_a_reg;
    assign quot_b    = q_b_reg;

endmodule

`default_nettype wire

>>> verif/tb_swept_aabb_collision.sv
`timescale 1ns / 100ps

module tb_swept_aabb_collision;

    localparam int CW = sac_pkg::COORD_WIDTH_DEF;
    localparam int TF = sac_pkg::TIME_FRAC_BITS_DEF;
    localparam int AW = sac_pkg::AXIS_WIDTH;
    localparam int EW = sac_pkg::EPS_WIDTH;
    localparam int NW = sac_pkg::NORMAL_WIDTH;

    localparam logic [AW-1:0] AXIS_X      = sac_pkg::AXIS_START;
    localparam logic [AW-1:0] AXIS_Y      = 2'd1;
    localparam logic [AW-1:0] AXIS_Z      = 2'd2;
    localparam logic [AW-1:0] AXIS_UNUSED = 2'd3;
    localparam logic [AW-1:0] LAST_AXIS   = AXIS_Z;

    localparam logic [NW-1:0] NORMAL_NEG_X = 3'd1;
    localparam logic [NW-1:0] NORMAL_POS_Y = 3'd4;

    localparam int Q_ONE = 65536;
    localparam int C_MIN = 32'sh8000_0000;
    localparam int C_MAX = 32'sh7fff_ffff;

    localparam longint TIME_ONE  = longint'(1) << TF;
    localparam longint TIME_SAT  = longint'(2) << TF;
    localparam logic [TF:0] TIME_HALF = 17'd32768;
    localparam logic [TF:0] TIME_FULL = 17'h10000;

    localparam logic [EW-1:0] EPS_MAX = 17'h10000;

    localparam int SETTLE_CYCLES = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 155;
    localparam int PHASES = 6;

    typedef struct {
        logic [AW-1:0]        axis;
        logic signed [CW-1:0] moving_min;
        logic signed [CW-1:0] moving_max;
        logic signed [CW-1:0] target_min;
        logic signed [CW-1:0] target_max;
        logic signed [CW-1:0] velocity;
    } axis_item_t;

    typedef struct {
        logic          hit;
        logic [TF:0]   hit_time;
        logic [NW-1:0] normal;
    } hit_report_t;

    typedef struct {
        axis_item_t  item;
        bit          typed;
        hit_report_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    sac_cfg_if cfg_ch ();
    sac_in_if  item_ch ();
    sac_out_if result_ch ();

    swept_aabb_collision DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .items   (item_ch),
        .results (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    logic [EW-1:0] eps_setting    = sac_pkg::EPS_RESET;
    longint        sweep_entry    = 0;
    longint        sweep_exit     = TIME_ONE;
    logic [NW-1:0] sweep_normal   = sac_pkg::NORMAL_NONE;
    bit            sweep_rejected = 1'b0;

    hit_report_t   expected_hits[$];
    directed_row_t directed[$];

    bit idling = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int axis_sent = 0;
    int eps_writes = 0;
    hit_report_t head_hit;

    // signed quotient in time format, truncated toward zero, clamped to +-2.0
    function automatic longint slab_time(input longint num, input longint den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (n >= 2 * d)
            q = TIME_SAT;
        else
            q = (n << TF) / d;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit sweep_axis(input axis_item_t it, output hit_report_t rep);
        longint near_gap;
        longint far_gap;
        longint vmag;
        longint t_lo;
        longint t_hi;
        longint t_tmp;
        bit     flip;
        rep.hit = 1'b0;
        rep.hit_time = '0;
        rep.normal = sac_pkg::NORMAL_NONE;
        if (it.axis > LAST_AXIS)
            return 1'b0;
        if (it.axis == AXIS_X)
        begin
            sweep_entry = 0;
            sweep_exit = TIME_ONE;
            sweep_normal = sac_pkg::NORMAL_NONE;
            sweep_rejected = 1'b0;
        end
        if (!sweep_rejected)
        begin
            near_gap = longint'(it.target_min) - longint'(it.moving_max);
            far_gap = longint'(it.target_max) - longint'(it.moving_min);
            vmag = (it.velocity < 0) ? -longint'(it.velocity) : longint'(it.velocity);
            if (it.velocity == 0 || vmag < longint'(eps_setting))
            begin
                if (near_gap > 0 || far_gap < 0)
                    sweep_rejected = 1'b1;
            end
            else
            begin
                t_lo = slab_time(near_gap, longint'(it.velocity));
                t_hi = slab_time(far_gap, longint'(it.velocity));
                flip = t_lo > t_hi;
                if (flip)
                begin
                    t_tmp = t_lo;
                    t_lo = t_hi;
                    t_hi = t_tmp;
                end
                if (t_lo > sweep_entry)
                begin
                    sweep_entry = t_lo;
                    sweep_normal = NW'({it.axis, 1'b0})
                        + (flip ? sac_pkg::NORMAL_PLUS_OFS : sac_pkg::NORMAL_MINUS_OFS);
                end
                if (t_hi < sweep_exit)
                    sweep_exit = t_hi;
                if (sweep_entry > sweep_exit)
                    sweep_rejected = 1'b1;
            end
        end
        if (it.axis != LAST_AXIS)
            return 1'b0;
        if (!sweep_rejected)
        begin
            rep.hit = (sweep_entry >= 0) && (sweep_entry < TIME_ONE);
            rep.hit_time = sweep_entry[TF:0];
            rep.normal = sweep_normal;
        end
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [AW-1:0] axis, input int mmin, input int mmax,
                                    input int tmin, input int tmax, input int vel,
                                    input bit typed = 1'b0, input logic hit = 1'b0,
                                    input logic [TF:0] hit_time = '0,
                                    input logic [NW-1:0] normal = sac_pkg::NORMAL_NONE);
        directed_row_t row;
        row.item.axis = axis;
        row.item.moving_min = mmin;
        row.item.moving_max = mmax;
        row.item.target_min = tmin;
        row.item.target_max = tmax;
        row.item.velocity = vel;
        row.typed = typed;
        row.want.hit = hit;
        row.want.hit_time = hit_time;
        row.want.normal = normal;
        directed.push_back(row);
    endfunction

    function automatic logic [CW-1:0] rand_span(input int bits);
        return CW'($urandom_range(0, 2 << bits)) - CW'(1 << bits);
    endfunction

    function automatic logic [CW-1:0] rand_wide();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic axis_item_t make_axis(input logic [AW-1:0] axis);
        axis_item_t it;
        logic [CW-1:0] base;
        logic [CW-1:0] swap;
        it.axis = axis;
        if ($urandom_range(0, 7) == 0)
        begin
            it.moving_min = rand_wide();
            it.moving_max = rand_wide();
            it.target_min = rand_wide();
            it.target_max = rand_wide();
            it.velocity = rand_wide();
            return it;
        end
        base = rand_span(18);
        it.moving_min = base;
        it.moving_max = base + CW'($urandom_range(0, 1 << 17));
        it.target_min = base + rand_span(18);
        it.target_max = it.target_min + CW'($urandom_range(0, 1 << 17));
        if ($urandom_range(0, 15) == 0)
        begin
            swap = it.target_min;
            it.target_min = it.target_max;
            it.target_max = swap;
        end
        case ($urandom_range(0, 9))
            0: it.velocity = '0;
            1: it.velocity = CW'($urandom_range(0, 2 * int'(eps_setting) + 2));
            2: it.velocity = CW'(eps_setting) + CW'($urandom_range(0, 2)) - 1;
            3: it.velocity = rand_wide();
            default: it.velocity = rand_span(19);
        endcase
        if ($urandom_range(0, 1) == 1)
            it.velocity = -it.velocity;
        return it;
    endfunction

    task automatic send_axis(input axis_item_t it, output bit due, output hit_report_t rep);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.axis_index <= it.axis;
        item_ch.moving_min <= it.moving_min;
        item_ch.moving_max <= it.moving_max;
        item_ch.target_min <= it.target_min;
        item_ch.target_max <= it.target_max;
        item_ch.velocity   <= it.velocity;
        do
            @(posedge clk);
        while (!item_ch.ready);
        axis_sent++;
        due = sweep_axis(it, rep);
    endtask

    task automatic send_random_test(inout int count);
        axis_item_t  it;
        bit          due;
        hit_report_t predicted;
        int          kind;
        int          first_axis;
        int          last_axis;
        int          a;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            it = make_axis(AXIS_UNUSED);
            send_axis(it, due, predicted);
            if (due)
                expected_hits.push_back(predicted);
            return;
        end
        first_axis = AXIS_X;
        last_axis = LAST_AXIS;
        if (kind == 1)
            first_axis = $urandom_range(AXIS_Y, AXIS_Z);
        else if (kind == 2)
            last_axis = $urandom_range(AXIS_X, AXIS_Y);
        for (a = first_axis; a <= last_axis; a++)
        begin
            it = make_axis(AW'(a));
            send_axis(it, due, predicted);
            if (due)
                expected_hits.push_back(predicted);
            count++;
        end
    endtask

    // hold until every expected result is back, then let the block settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_eps(input logic [EW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        eps_setting = value;
        eps_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit=%0d time=%0d normal=%0d",
                         $time, result_ch.hit, result_ch.hit_time, result_ch.normal_code);
                mismatches++;
            end
            else
            begin
                head_hit = expected_hits.pop_front();
                check_field("hit", 32'(head_hit.hit), 32'(result_ch.hit));
                check_field("hit_time", 32'(head_hit.hit_time), 32'(result_ch.hit_time));
                check_field("normal_code", 32'(head_hit.normal), 32'(result_ch.normal_code));
                if (head_hit.hit)
                    hits_seen++;
            end
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 12) - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        bit            due;
        hit_report_t   predicted;
        logic [EW-1:0] eps_plan[PHASES];
        int            p;
        int            phase_count;

        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        item_ch.valid = 1'b0;
        item_ch.axis_index = '0;
        item_ch.moving_min = '0;
        item_ch.moving_max = '0;
        item_ch.target_min = '0;
        item_ch.target_max = '0;
        item_ch.velocity = '0;
        result_ch.ready = 1'b0;

        // resting overlap on every axis
        add_row(AXIS_X, 0, 0, 0, 0, 0);
        add_row(AXIS_Y, 0, 0, 0, 0, 0);
        add_row(AXIS_Z, 0, 0, 0, 0, 0, 1'b1, 1'b1, '0, sac_pkg::NORMAL_NONE);
        // slow x counts as static and misses; rejection holds through a moving y
        add_row(AXIS_X, 0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -65);
        add_row(AXIS_Y, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX);
        add_row(AXIS_Z, 0, 0, 0, 0, 0, 1'b1, 1'b0, '0, sac_pkg::NORMAL_NONE);
        // enter through the minus x face halfway through the step
        add_row(AXIS_X, 0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 2 * Q_ONE);
        add_row(AXIS_Y, 0, 0, 0, 0, 0);
        add_row(AXIS_Z, 0, 0, 0, 0, 0, 1'b1, 1'b1, TIME_HALF, NORMAL_NEG_X);
        // enter through the plus y face
        add_row(AXIS_X, 0, 0, 0, 0, 0);
        add_row(AXIS_Y, 2 * Q_ONE, 3 * Q_ONE, 0, Q_ONE, -2 * Q_ONE);
        add_row(AXIS_Z, 0, 0, 0, 0, 0, 1'b1, 1'b1, TIME_HALF, NORMAL_POS_Y);
        // quotient clamps to 2.0 and passes the exit
        add_row(AXIS_X, 0, 0, Q_ONE, 2 * Q_ONE, 100);
        add_row(AXIS_Y, 0, 0, 0, 0, 0);
        add_row(AXIS_Z, 0, 0, 0, 0, 0, 1'b1, 1'b0, '0, sac_pkg::NORMAL_NONE);
        // entry equals exit at 1.0, with an out of range axis dropped in between
        add_row(AXIS_X, 0, 0, Q_ONE, Q_ONE, Q_ONE);
        add_row(AXIS_UNUSED, C_MIN, C_MAX, -1, Q_ONE, C_MIN);
        add_row(AXIS_Y, 0, 0, 0, 0, 0);
        add_row(AXIS_Z, 0, 0, 0, 0, 0, 1'b1, 1'b0, TIME_FULL, NORMAL_NEG_X);
        // widest coordinates and the most negative velocity
        add_row(AXIS_X, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
        add_row(AXIS_Y, 0, 0, 0, 0, 0);
        add_row(AXIS_Z, 0, 0, 0, 0, 0, 1'b1, 1'b1, '0, sac_pkg::NORMAL_NONE);
        // no x to start the test, inverted boxes
        add_row(AXIS_Y, Q_ONE, 0, 3 * Q_ONE, -Q_ONE, C_MAX);
        add_row(AXIS_Z, C_MAX, C_MIN, 0, 0, 1);

        eps_plan[0] = '0;
        eps_plan[1] = EPS_MAX;
        eps_plan[2] = EW'($urandom_range(0, 300));
        eps_plan[3] = EPS_MAX - 1;
        eps_plan[4] = EW'($urandom_range(0, EPS_MAX));
        eps_plan[5] = sac_pkg::EPS_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_axis(directed[i].item, due, predicted);
            if (due)
            begin
                if (directed[i].typed)
                    expected_hits.push_back(directed[i].want);
                else
                    expected_hits.push_back(predicted);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            write_eps(eps_plan[p]);
            if (p == PHASES - 1)
                idling = 1'b0;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                if (p != PHASES - 1 && $urandom_range(0, 31) == 0)
                    idling = !idling;
                send_random_test(phase_count);
            end
        end
        drain();

        $display("Sent %0d axis transactions under %0d eps_velocity settings (0 and 65536 included)",
                 axis_sent, eps_writes);
        $display("Checked %0d collision results: %0d hits, %0d misses or rejections",
                 results_seen, hits_seen, results_seen - hits_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
design/sac_pkg.sv
design/sac_if.sv
design/sac_div.sv
design/swept_aabb_collision.sv
verif/tb_swept_aabb_collision.sv
